### src/pmi_pkg.sv
// pmi_pkg: shared types and constants of the point mass integrator
// no dependencies
package pmi_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [31:0] MASS_RESET = 32'd65536;

  localparam logic [1:0] MODE_EULER = 2'd0;
  localparam logic [1:0] MODE_RK2 = 2'd1;
  localparam logic [1:0] MODE_RK4 = 2'd2;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [0:0] REG_MASS = 1'b0;
  localparam logic [0:0] REG_MODE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [15:0]        time_step;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_pos_z;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_vel_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } out_req_t;

  // clamp a 36-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

### src/point_mass_integrator_top.sv
// point mass integrator, top level: sequencer with a shared divider and multiplier
// depends on pmi_pkg
//
//  channel | direction | handshake           | payload
//  in_     | in        | in_valid/in_stall   | pmi_pkg::in_req_t
//  out_    | out       | out_valid/out_stall | pmi_pkg::out_req_t
//  cfg_    | in        | apb psel/penable    | body_mass @0, integrator_mode @4
//
// a load passes through S_LOAD to the result; a step works the three axes in turn
// per axis each k term is a bit-serial divide by the mass with setup and finish, one
// multiply and one sum; rk4 then divides by six in S_SIX and S_SIXDIV
// each axis then multiplies its velocity by dt and adds both steps to position and velocity
// zero mass skips the divide loop
// synchronous active-low reset clears state to zero, mass to 65536 (one at the default FRAC_BITS), mode to euler
// one request at a time: in_stall stays high from accept until the result is taken
module point_mass_integrator_top #(
  parameter int FRAC_BITS = pmi_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pmi_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pmi_pkg::out_req_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  // dividend width: |F| shifted up by FRAC_BITS
  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  // ceil(2^20 / 3): exact quotient by three for operands below 2^19
  localparam logic [18:0] THIRD_RECIP = 19'd349526;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DIVSET, S_DIV, S_MUL, S_KSUM, S_SIX, S_SIXDIV,
    S_VEL, S_PMUL, S_POS, S_NEXT, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] mass_r;
  logic [1:0] mode_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic [1:0] axis_r;
  logic [1:0] kidx_r;
  logic [15:0] dt_r;
  logic signed [31:0] frc_r [3];
  logic signed [31:0] k_r;      // last k term, then the position step
  logic signed [35:0] acc_r;    // rk4 weighted sum
  logic signed [31:0] dv_r;
  // shared divider
  logic [DW-1:0] quo_r;
  logic [32:0] rem_r;
  logic [31:0] dvsr_r;
  logic [CW-1:0] cnt_r;
  logic dneg_r;
  // divide by six: upper quotient, upper remainder and lower half of the halved sum
  logic [15:0] six_hq_r;
  logic [1:0] six_rh_r;
  logic [16:0] six_lo_r;

  logic wr;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    unique case (cfg_paddr[2])
      pmi_pkg::REG_MASS: cfg_prdata = mass_r;
      pmi_pkg::REG_MODE: cfg_prdata = {30'd0, mode_r};
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = '{pos_x: pos_r[0], pos_y: pos_r[1], pos_z: pos_r[2],
                      vel_x: vel_r[0], vel_y: vel_r[1], vel_z: vel_r[2]};

  // shared restoring divider step
  logic [32:0] trial;
  logic [32:0] rem_sh;
  assign rem_sh = {rem_r[31:0], quo_r[DW-1]};
  assign trial = rem_sh - {1'b0, dvsr_r};

  // shared multiplier: magnitude times dt
  logic [31:0] mop;
  logic mneg;
  logic signed [31:0] msrc;
  logic [47:0] mprod;
  logic [47:0] mshift;
  logic signed [31:0] mres;
  always_comb begin
    msrc = (state_r == S_PMUL) ? vel_r[axis_r] : k_r;
    mneg = msrc[31];
    mop = mneg ? (32'd0 - msrc) : msrc;
    mprod = {16'd0, mop} * {32'd0, dt_r};
    mshift = mprod >> FRAC_BITS;
    // saturate unless the magnitude fits, or is exactly 2^31 on the negative side
    if (|mshift[47:31] && !(mneg && mshift == 48'h0000_8000_0000))
      mres = mneg ? 32'sh80000000 : 32'sh7fffffff;
    else mres = mneg ? (32'sd0 - mshift[31:0]) : mshift[31:0];
  end

  // quotient result with saturation
  logic signed [31:0] qres;
  always_comb begin
    if (|quo_r[DW-1:31] && !(dneg_r && quo_r == {{(DW-32){1'b0}}, 1'b1, 31'd0}))
      qres = dneg_r ? 32'sh80000000 : 32'sh7fffffff;
    else qres = dneg_r ? (32'sd0 - quo_r[31:0]) : quo_r[31:0];
  end

  // dividend for the next k term
  logic signed [35:0] fsum;
  logic signed [31:0] khalf;
  always_comb begin
    // halve toward zero: negative values round up before the arithmetic shift
    khalf = $signed(k_r + {31'd0, k_r[31]}) >>> 1;
    unique case (kidx_r)
      2'd0:    fsum = 36'(frc_r[axis_r]);
      2'd1:    fsum = 36'(frc_r[axis_r]) + 36'(khalf);
      default: fsum = 36'(frc_r[axis_r]) + 36'(k_r);
    endcase
  end

  logic signed [31:0] fsat;
  logic [31:0] fmag;
  assign fsat = pmi_pkg::sat36(fsum);
  assign fmag = fsat[31] ? (32'd0 - fsat) : fsat;
  logic [35:0] amag;
  assign amag = acc_r[35] ? (36'd0 - acc_r) : acc_r;

  // |sum| / 6 = (|sum| >> 1) / 3, split into two 17-bit halves each divided by three
  logic [16:0] six_hi;
  logic [35:0] six_hprod;
  logic [15:0] six_hq;
  logic [16:0] six_hrem;
  logic [37:0] six_lprod;
  logic [32:0] six_q;
  assign six_hi = amag[34:18];
  assign six_hprod = {19'd0, six_hi} * {17'd0, THIRD_RECIP};
  assign six_hq = six_hprod[35:20];
  assign six_hrem = six_hi - ({1'b0, six_hq} + {six_hq, 1'b0});
  assign six_lprod = {19'd0, six_rh_r, six_lo_r} * {19'd0, THIRD_RECIP};
  assign six_q = {six_hq_r, six_lprod[36:20]};

  logic last_k;
  always_comb begin
    if (mode_r == pmi_pkg::MODE_RK2) last_k = (kidx_r == 2'd1);
    else if (mode_r == pmi_pkg::MODE_RK4) last_k = (kidx_r == 2'd3);
    else last_k = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mass_r <= pmi_pkg::MASS_RESET;
      mode_r <= pmi_pkg::MODE_EULER;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      axis_r <= '0;
      kidx_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        if (cfg_paddr[2] == pmi_pkg::REG_MASS) mass_r <= cfg_pwdata;
        else mode_r <= cfg_pwdata[1:0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dt_r <= in_data.time_step;
            frc_r[0] <= in_data.force_x;
            frc_r[1] <= in_data.force_y;
            frc_r[2] <= in_data.force_z;
            pos_r[0] <= in_data.command ? in_data.load_pos_x : pos_r[0];
            pos_r[1] <= in_data.command ? in_data.load_pos_y : pos_r[1];
            pos_r[2] <= in_data.command ? in_data.load_pos_z : pos_r[2];
            vel_r[0] <= in_data.command ? in_data.load_vel_x : vel_r[0];
            vel_r[1] <= in_data.command ? in_data.load_vel_y : vel_r[1];
            vel_r[2] <= in_data.command ? in_data.load_vel_z : vel_r[2];
            axis_r <= '0;
            kidx_r <= '0;
            acc_r <= '0;
            state_r <= (in_data.command == pmi_pkg::CMD_LOAD) ? S_LOAD : S_DIVSET;
          end
        end
        S_LOAD: state_r <= S_OUT;
        S_DIVSET: begin
          dneg_r <= fsat[31];
          quo_r <= {fmag, {FRAC_BITS{1'b0}}};
          rem_r <= '0;
          dvsr_r <= mass_r;
          cnt_r <= CW'(DW);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (dvsr_r == 32'd0) begin
            // zero mass: full scale with the sign of the force, zero for zero force
            k_r <= (quo_r == '0) ? 32'sd0 : (dneg_r ? 32'sh80000000 : 32'sh7fffffff);
            state_r <= S_MUL;
          end else if (cnt_r == '0) begin
            k_r <= qres;
            state_r <= S_MUL;
          end else begin
            if (!trial[32]) begin
              rem_r <= trial;
              quo_r <= {quo_r[DW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[DW-2:0], 1'b0};
            end
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_MUL: begin
          k_r <= mres;
          state_r <= S_KSUM;
        end
        S_KSUM: begin
          // weights 1,2,2,1 for rk4
          if (kidx_r == 2'd1 || kidx_r == 2'd2) acc_r <= acc_r + 36'(k_r) + 36'(k_r);
          else acc_r <= acc_r + 36'(k_r);
          dv_r <= k_r;
          if (last_k) state_r <= (mode_r == pmi_pkg::MODE_RK4) ? S_SIX : S_VEL;
          else begin
            kidx_r <= kidx_r + 1'b1;
            state_r <= S_DIVSET;
          end
        end
        S_SIX: begin
          dneg_r <= acc_r[35];
          six_hq_r <= six_hq;
          six_rh_r <= six_hrem[1:0];
          six_lo_r <= amag[17:1];
          state_r <= S_SIXDIV;
        end
        S_SIXDIV: begin
          dv_r <= dneg_r ? 32'(33'd0 - six_q) : six_q[31:0];
          state_r <= S_VEL;
        end
        S_VEL: state_r <= S_PMUL;
        S_PMUL: begin
          k_r <= mres;
          state_r <= S_POS;
        end
        S_POS: begin
          pos_r[axis_r] <= pmi_pkg::sat36(36'(pos_r[axis_r]) + 36'(k_r));
          vel_r[axis_r] <= pmi_pkg::sat36(36'(vel_r[axis_r]) + 36'(dv_r));
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          kidx_r <= '0;
          acc_r <= '0;
          if (axis_r == 2'd2) state_r <= S_OUT;
          else begin
            axis_r <= axis_r + 1'b1;
            state_r <= S_DIVSET;
          end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // never index past the third axis
  ap_axis: assert property (@(posedge clk) disable iff (!rst_n) axis_r != 2'd3)
    else $error("axis index out of range");
  // only idle takes a request
  ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("request taken while busy");
  // a result holds while stalled
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result dropped under stall");
endmodule
